/* sv/multi_format_text_encoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-format text encoder
// Shorthand for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_FORMAT_TEXT_ENCODER_UNIT_ASSERT_SVH
`define MULTI_FORMAT_TEXT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MFTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define MFTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* sv/mfte_pkg.sv */
// ----------------------------------------------------------------------------
// mfte_pkg
// Types, constants and character functions of the multi-format text encoder.
// ----------------------------------------------------------------------------
package mfte_pkg;

  typedef enum logic [2:0] {
    FMT_RAW     = 3'd0,
    FMT_PERCENT = 3'd1,
    FMT_BASE64  = 3'd2,
    FMT_HEX     = 3'd3,
    FMT_FRAMED  = 3'd4,
    FMT_IGNORE  = 3'd5
  } fmt_e;

  localparam logic CFG_FORMAT    = 1'b0;
  localparam logic CFG_HEX_UPPER = 1'b1;

  localparam int unsigned CNT_W       = 17;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_CHARS   = 4;

  localparam logic [7:0] CH_STX     = 8'h02;
  localparam logic [7:0] CH_ETX     = 8'h03;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_TILDE   = 8'h7e;
  localparam logic [7:0] CH_APOS    = 8'h27;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                num;
    logic                      last;
  } entry_t;

  function automatic logic [7:0] nibble_char(input logic [3:0] n, input logic upper);
    logic [7:0] adj;
    adj = 8'h00;
    if (n > 4'd9) begin
      adj = upper ? 8'h07 : 8'h27;
    end
    return {4'h0, n} + 8'h30 + adj;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] n);
    logic [7:0] c;
    if (n < 6'd26) begin
      c = {2'b00, n} + 8'h41;
    end else if (n < 6'd52) begin
      c = {2'b00, n} - 8'd26 + 8'h61;
    end else if (n < 6'd62) begin
      c = {2'b00, n} - 8'd52 + 8'h30;
    end else if (n == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  function automatic logic percent_kept(input logic [7:0] c);
    logic k;
    k = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
        (c >= 8'h61 && c <= 8'h7a) || c == 8'h2d || c == 8'h5f ||
        c == 8'h2e || c == CH_TILDE || c == 8'h21 || c == 8'h28 ||
        c == 8'h29 || c == 8'h2a || c == CH_APOS;
    return k;
  endfunction

endpackage

/* sv/mfte_front.sv */
// ----------------------------------------------------------------------------
// mfte_front
// Accepts message bytes and turns each into a group of up to four characters.
// ----------------------------------------------------------------------------
module mfte_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfte_pkg::fmt_e       fmt_i,
  input  logic                 hex_upper_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output mfte_pkg::entry_t     q_entry_o
);

  logic [3:0] lo_bits_q, lo_bits_d;
  logic [2:0] lo_cnt_q, lo_cnt_d;
  logic       start_q, start_d;
  logic       accept;
  logic [3:0] b64_bits;
  logic [2:0] b64_cnt;
  mfte_pkg::entry_t ent;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    ent       = '0;
    ent.last  = in_last_i;
    b64_bits  = 4'h0;
    b64_cnt   = 3'd0;
    case (fmt_i)
      mfte_pkg::FMT_PERCENT: begin
        if (mfte_pkg::percent_kept(in_byte_i)) begin
          ent.chars[0] = in_byte_i;
          ent.num      = 3'd1;
        end else begin
          ent.chars[0] = mfte_pkg::CH_PERCENT;
          ent.chars[1] = mfte_pkg::nibble_char(in_byte_i[7:4], hex_upper_i);
          ent.chars[2] = mfte_pkg::nibble_char(in_byte_i[3:0], hex_upper_i);
          ent.num      = 3'd3;
        end
      end
      mfte_pkg::FMT_BASE64: begin
        case (lo_cnt_q)
          3'd0: begin
            ent.chars[0] = mfte_pkg::b64_char(in_byte_i[7:2]);
            b64_bits     = {2'b00, in_byte_i[1:0]};
            b64_cnt      = 3'd2;
            if (in_last_i) begin
              ent.chars[1] = mfte_pkg::b64_char({in_byte_i[1:0], 4'h0});
              ent.chars[2] = mfte_pkg::CH_EQUAL;
              ent.chars[3] = mfte_pkg::CH_EQUAL;
              ent.num      = 3'd4;
            end else begin
              ent.num      = 3'd1;
            end
          end
          3'd2: begin
            ent.chars[0] = mfte_pkg::b64_char({lo_bits_q[1:0], in_byte_i[7:4]});
            b64_bits     = in_byte_i[3:0];
            b64_cnt      = 3'd4;
            if (in_last_i) begin
              ent.chars[1] = mfte_pkg::b64_char({in_byte_i[3:0], 2'b00});
              ent.chars[2] = mfte_pkg::CH_EQUAL;
              ent.num      = 3'd3;
            end else begin
              ent.num      = 3'd1;
            end
          end
          default: begin
            ent.chars[0] = mfte_pkg::b64_char({lo_bits_q, in_byte_i[7:6]});
            ent.chars[1] = mfte_pkg::b64_char(in_byte_i[5:0]);
            ent.num      = 3'd2;
          end
        endcase
      end
      mfte_pkg::FMT_HEX: begin
        ent.chars[0] = mfte_pkg::nibble_char(in_byte_i[7:4], hex_upper_i);
        ent.chars[1] = mfte_pkg::nibble_char(in_byte_i[3:0], hex_upper_i);
        ent.num      = 3'd2;
      end
      mfte_pkg::FMT_FRAMED: begin
        if (start_q) begin
          ent.chars[0] = mfte_pkg::CH_STX;
          ent.chars[1] = in_byte_i;
          ent.chars[2] = mfte_pkg::CH_ETX;
          ent.num      = in_last_i ? 3'd3 : 3'd2;
        end else begin
          ent.chars[0] = in_byte_i;
          ent.chars[1] = mfte_pkg::CH_ETX;
          ent.num      = in_last_i ? 3'd2 : 3'd1;
        end
      end
      mfte_pkg::FMT_IGNORE: begin
        ent.num = 3'd0;
      end
      default: begin
        ent.chars[0] = in_byte_i;
        ent.num      = 3'd1;
      end
    endcase
  end

  always_comb begin
    lo_bits_d = lo_bits_q;
    lo_cnt_d  = lo_cnt_q;
    start_d   = start_q;
    if (accept) begin
      if (in_last_i) begin
        lo_bits_d = 4'h0;
        lo_cnt_d  = 3'd0;
        start_d   = 1'b1;
      end else begin
        start_d = 1'b0;
        if (fmt_i == mfte_pkg::FMT_BASE64) begin
          lo_bits_d = b64_bits;
          lo_cnt_d  = b64_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_bits_q <= 4'h0;
      lo_cnt_q  <= 3'd0;
      start_q   <= 1'b1;
    end else begin
      lo_bits_q <= lo_bits_d;
      lo_cnt_q  <= lo_cnt_d;
      start_q   <= start_d;
    end
  end

  assign q_push_o  = accept && (ent.num != 3'd0 || in_last_i);
  assign q_entry_o = ent;

endmodule

/* sv/mfte_queue.sv */
// ----------------------------------------------------------------------------
// mfte_queue
// Short FIFO of character groups between the front and the back.
// ----------------------------------------------------------------------------
module mfte_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mfte_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output mfte_pkg::entry_t head_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(mfte_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(mfte_pkg::QUEUE_DEPTH + 1);

  mfte_pkg::entry_t slots_q [mfte_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CntW'(mfte_pkg::QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(mfte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(mfte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* sv/mfte_back.sv */
// ----------------------------------------------------------------------------
// mfte_back
// Sends the queued characters one per cycle while the output is ready and keeps the character count of each message.
// ----------------------------------------------------------------------------
module mfte_back #(
  parameter logic [mfte_pkg::CNT_W-1:0] CountCap = 17'd98301
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mfte_pkg::entry_t            head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_char_o,
  output logic                        out_last_o,
  output logic [mfte_pkg::CNT_W-1:0]  out_total_o
);

  logic [1:0]                 idx_q, idx_d;
  logic [mfte_pkg::CNT_W-1:0] total_q, total_d;
  logic                       valid_q, valid_d;
  logic                       last_q, last_d;
  logic [7:0]                 char_q, char_d;
  logic [mfte_pkg::CNT_W-1:0] tot_out_q, tot_out_d;
  logic [mfte_pkg::CNT_W-1:0] inc;
  logic                       load, is_final;

  assign load     = !valid_q || out_ready_i;
  assign inc      = (total_q < CountCap) ? total_q + 1'b1 : total_q;
  assign is_final = ({1'b0, idx_q} + 3'd1 == head_i.num);

  always_comb begin
    pop_o     = 1'b0;
    idx_d     = idx_q;
    total_d   = total_q;
    valid_d   = valid_q && !out_ready_i;
    last_d    = last_q;
    char_d    = char_q;
    tot_out_d = tot_out_q;
    if (!empty_i && load) begin
      if (head_i.num == 3'd0) begin
        pop_o   = 1'b1;
        total_d = '0;
      end else begin
        valid_d   = 1'b1;
        char_d    = head_i.chars[idx_q];
        last_d    = is_final && head_i.last;
        tot_out_d = (is_final && head_i.last) ? inc : '0;
        if (is_final) begin
          pop_o   = 1'b1;
          idx_d   = 2'd0;
          total_d = head_i.last ? '0 : inc;
        end else begin
          idx_d   = idx_q + 2'd1;
          total_d = inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      total_q <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      total_q <= total_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q    <= char_d;
    tot_out_q <= tot_out_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign out_total_o = tot_out_q;

endmodule

/* sv/multi_format_text_encoder_unit.sv */
// ----------------------------------------------------------------------------
// multi_format_text_encoder_unit
// Byte stream to raw, percent, base64, hex, STX/ETX framed or no characters.
// ----------------------------------------------------------------------------
// The output sends one character per cycle while the receiver is ready, and a
// byte produces one character when raw, one to three when framed (STX before
// the first byte of a message, ETX after the last), two for hex, one or
// three for percent, one to four for base64 (up to four on a final
// byte with padding), none for ignore. The output character register is the
// limit; the input accepts one word per cycle as long as the two-entry queue
// between the encoder and the output has room. The final character of a
// message carries the character count of that message, saturating at three
// times MAX_MESSAGE_BYTES. Write the configuration only while the block is idle.
module multi_format_text_encoder_unit #(
  parameter int unsigned MAX_MESSAGE_BYTES = 32767
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] out_char, [24:8] char_total
  output logic        m_axis_tlast_o
);

  localparam logic [mfte_pkg::CNT_W-1:0] CountCap =
    mfte_pkg::CNT_W'(3 * MAX_MESSAGE_BYTES);

  mfte_pkg::fmt_e             fmt_q;
  logic                       hex_upper_q;
  logic                       q_push, q_full, q_pop, q_empty;
  mfte_pkg::entry_t           q_in, q_head;
  logic [7:0]                 out_char;
  logic [mfte_pkg::CNT_W-1:0] out_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= mfte_pkg::FMT_RAW;
      hex_upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == mfte_pkg::CFG_FORMAT) begin
        fmt_q <= mfte_pkg::fmt_e'(cfg_wdata_i);
      end else if (cfg_addr_i == mfte_pkg::CFG_HEX_UPPER) begin
        hex_upper_q <= cfg_wdata_i[0];
      end
    end
  end

  mfte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_i       (fmt_q),
    .hex_upper_i (hex_upper_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  mfte_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .empty_o      (q_empty)
  );

  mfte_back #(
    .CountCap (CountCap)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o),
    .out_total_o (out_total)
  );

  assign m_axis_tdata_o = {7'b0, out_total, out_char};

endmodule

/* sv/mfte_checker.sv */
// ----------------------------------------------------------------------------
// mfte_checker
// Port-level checks of the encoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_format_text_encoder_unit_assert.svh"

module mfte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_i,
  input logic        m_axis_tlast_i
);

  logic        out_stall;
  logic        out_mid;
  logic        out_end;
  logic [32:0] out_word;
  logic [16:0] char_total;

  assign out_stall  = m_axis_tvalid_i && !m_axis_tready_i;
  assign out_mid    = m_axis_tvalid_i && !m_axis_tlast_i;
  assign out_end    = m_axis_tvalid_i && m_axis_tlast_i;
  assign out_word   = {m_axis_tlast_i, m_axis_tdata_i};
  assign char_total = m_axis_tdata_i[24:8];

  `MFTE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_i && $stable(out_word))
  `MFTE_ASSERT_IMP(a_total_only_last, clk_i, rst_ni, out_mid, char_total == 17'd0)
  `MFTE_ASSERT_IMP(a_total_nonzero, clk_i, rst_ni, out_end, char_total != 17'd0)
  `MFTE_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_i, m_axis_tdata_i[31:25] == 7'd0)

endmodule

bind multi_format_text_encoder_unit mfte_checker u_mfte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
